/* hw/rtl/timed_note_queue_player_assert.svh */
// Assertion macros used by the note player RTL.
`ifndef TIMED_NOTE_QUEUE_PLAYER_ASSERT_SVH
`define TIMED_NOTE_QUEUE_PLAYER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TNQP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnqp: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TNQP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnqp: next-cycle check failed");

`endif

/* hw/rtl/tnqp_pkg.sv */
`default_nettype none
package tnqp_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int PTR_W       = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

  localparam int OP_W    = 3;
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 24;
  localparam int ELAP_W  = 20;
  localparam int CD_W    = DUR_W + 1;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd1;
  localparam logic [OP_W-1:0] OP_PLAY    = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [FREQ_W-1:0] note_freq;
    logic [DUR_W-1:0]  note_dur;
    logic [ELAP_W-1:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] beep_freq;
    logic [DUR_W-1:0]  beep_dur;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic enq;
    logic play;
    logic stop;
    logic clear;
    logic tick;
    logic pop;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic playing;
    logic empty;
    logic full;
    logic expired;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/tnqp_ctrl.sv */
`default_nettype none
module tnqp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [2:0]           opcode,
  output logic                      in_stall,
  input  wire tnqp_pkg::dp_stat_t   stat,
  output tnqp_pkg::ctl_cmd_t        cmd
);
  import tnqp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic state_r;
  logic state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (opcode)
            OP_TICK: begin
              if (stat.playing) begin
                cmd.tick = 1'b1;
                if (stat.expired && !stat.empty) begin
                  state_nxt = ST_POP;
                end
              end
            end
            OP_ENQUEUE: cmd.enq   = !stat.full;
            OP_PLAY:    cmd.play  = 1'b1;
            OP_STOP:    cmd.stop  = 1'b1;
            OP_CLEAR:   cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_POP: begin
        // wait for the output register to free up
        if (!stat.out_busy) begin
          cmd.pop   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/tnqp_datapath.sv */
`default_nettype none
module tnqp_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tnqp_pkg::in_item_t   in_item,
  input  wire tnqp_pkg::ctl_cmd_t   cmd,
  output tnqp_pkg::dp_stat_t        stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tnqp_pkg::out_item_t       out_item
);
  import tnqp_pkg::*;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

  out_item_t               note_store_r [QUEUE_SLOTS];
  out_item_t               rd_note_r;
  logic [PTR_W-1:0]        rd_slot_r, rd_slot_nxt;
  logic [PTR_W-1:0]        wr_slot_r, wr_slot_nxt;
  logic                    playing_r, playing_nxt;
  logic signed [CD_W-1:0]  countdown_r, countdown_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r;
  logic [PTR_W-1:0]        wr_next;
  logic [PTR_W-1:0]        rd_next;
  logic signed [CD_W-1:0]  cd_sub;

  assign wr_next = (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + PTR_W'(1);
  assign rd_next = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + PTR_W'(1);
  assign cd_sub  = countdown_r - $signed({{(CD_W-ELAP_W){1'b0}}, in_item.elapsed});

  assign stat.playing  = playing_r;
  assign stat.empty    = (rd_slot_r == wr_slot_r);
  assign stat.full     = (wr_next == rd_slot_r);
  assign stat.expired  = cd_sub[CD_W-1] || (cd_sub == '0);
  assign stat.out_busy = out_valid_r && out_stall;

  // note store: one write port, one registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      note_store_r[wr_slot_r] <= '{beep_freq: in_item.note_freq, beep_dur: in_item.note_dur};
    end
    rd_note_r <= note_store_r[rd_slot_r];
  end

  always_comb begin
    rd_slot_nxt   = rd_slot_r;
    wr_slot_nxt   = wr_slot_r;
    playing_nxt   = playing_r;
    countdown_nxt = countdown_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.clear) begin
      rd_slot_nxt   = '0;
      wr_slot_nxt   = '0;
      playing_nxt   = 1'b0;
      countdown_nxt = '0;
    end
    if (cmd.enq)  wr_slot_nxt = wr_next;
    if (cmd.play) playing_nxt = 1'b1;
    if (cmd.stop) playing_nxt = 1'b0;
    if (cmd.tick) countdown_nxt = stat.expired ? '0 : cd_sub;
    if (cmd.pop) begin
      rd_slot_nxt   = rd_next;
      countdown_nxt = $signed({1'b0, rd_note_r.beep_dur});
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r   <= '0;
      wr_slot_r   <= '0;
      playing_r   <= 1'b0;
      countdown_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_slot_r   <= rd_slot_nxt;
      wr_slot_r   <= wr_slot_nxt;
      playing_r   <= playing_nxt;
      countdown_r <= countdown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_item_r <= rd_note_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

/* hw/rtl/timed_note_queue_player.sv */
`default_nettype none
// Timed note queue player: a ring FIFO of notes (Q12.4 Hz frequency plus a
// duration in us) feeding a countdown sequencer.
// Input channel (in_valid / in_stall / in_item): opcode tick, enqueue, play,
// stop or clear; unused opcodes are swallowed with no effect.
// Output channel (out_valid / out_stall / out_item): one beep item for each
// tick, while playing, that finds the countdown run out and a note waiting.
// The queue holds QUEUE_SLOTS-1 notes; an enqueue into a full queue is dropped.
// Timing: only a popping tick stalls the input; it moves the controller to its
// pop state, where the head note from the store's registered read port is loaded
// into the output register and out_valid rises, so the next item waits behind it.
// If the previous beep is still held by out_stall, the pop waits and in_stall
// stays high until the output register is free.
// Reset (rst_n low, synchronous): pointers, playing flag, countdown, output
// valid and controller state clear. The note store is not cleared; only
// slots written since the last clear are ever read.
module timed_note_queue_player (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tnqp_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tnqp_pkg::out_item_t       out_item
);
  import tnqp_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     pop_tick;

  // sequencer: opcode decode, pop wait state
  tnqp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .opcode   (in_item.opcode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queue store, pointers, countdown and output register
  tnqp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a tick that will produce a beep
  assign pop_tick = cmd.tick && stat.expired && !stat.empty;

`include "timed_note_queue_player_assert.svh"

  // never pop an empty queue, never write a full one
  `TNQP_ASSERT_NOW(a_pop_not_empty, cmd.pop, !stat.empty)
  `TNQP_ASSERT_NOW(a_enq_not_full, cmd.enq, !stat.full)
  // a popping tick blocks the input until its beep is loaded
  `TNQP_ASSERT_NEXT(a_pop_blocks_input, pop_tick, in_stall)
  // a pop always lands in the output register
  `TNQP_ASSERT_NEXT(a_pop_shows_beep, cmd.pop, out_valid)

endmodule
`default_nettype wire

/* dv/timed_note_queue_player_tb.sv */
`default_nettype none
module timed_note_queue_player_tb;
  import tnqp_pkg::*;

  // Run length and pacing knobs
  localparam int RUN_LIMIT    = 200000;  // cycles; far above the slowest legal run
  localparam int RANDOM_ITEMS = 550;     // counted items in the random part
  localparam int SETTLE_CYCLES = 8;      // slack for a popping tick still in flight

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  // Note queue tracker: mirrors the ring store, pointers, play flag and
  // countdown, and keeps the beeps still owed by the block in order.
  class beep_scoreboard;
    logic [FREQ_W-1:0] freq_mem [QUEUE_SLOTS];
    logic [DUR_W-1:0]  dur_mem  [QUEUE_SLOTS];
    int unsigned       head_slot;
    int unsigned       tail_slot;
    bit                playing;
    int                countdown;   // signed microseconds, always fits 25 bits
    out_item_t         owed_beeps[$];
    int                errors;

    function new();
      head_slot = 0;
      tail_slot = 0;
      playing   = 1'b0;
      countdown = 0;
      errors    = 0;
    endfunction

    function int unsigned step_slot(int unsigned slot);
      return (slot + 1) % QUEUE_SLOTS;
    endfunction

    function int pending();
      return owed_beeps.size();
    endfunction

    // Update the mirror for one accepted item; queue a beep if it pops.
    function void note_input(in_item_t it);
      out_item_t beep;
      case (it.opcode)
        OP_TICK: begin
          if (playing) begin
            countdown -= int'(it.elapsed);
            if (countdown <= 0) begin
              if (head_slot == tail_slot) begin
                countdown = 0;
              end else begin
                beep.beep_freq = freq_mem[head_slot];
                beep.beep_dur  = dur_mem[head_slot];
                owed_beeps.push_back(beep);
                countdown = int'(dur_mem[head_slot]);
                head_slot = step_slot(head_slot);
              end
            end
          end
        end
        OP_ENQUEUE: begin
          if (step_slot(tail_slot) != head_slot) begin
            freq_mem[tail_slot] = it.note_freq;
            dur_mem[tail_slot]  = it.note_dur;
            tail_slot = step_slot(tail_slot);
          end
        end
        OP_PLAY: playing = 1'b1;
        OP_STOP: playing = 1'b0;
        OP_CLEAR: begin
          head_slot = 0;
          tail_slot = 0;
          playing   = 1'b0;
          countdown = 0;
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted beep with the oldest one owed.
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_beeps.size() == 0) begin
        $display("%0t: unexpected beep, expected none, got freq %h dur %h",
                 $time, got.beep_freq, got.beep_dur);
        errors++;
        return;
      end
      want = owed_beeps.pop_front();
      if (got.beep_freq !== want.beep_freq) begin
        $display("%0t: beep_freq mismatch, expected %h, got %h",
                 $time, want.beep_freq, got.beep_freq);
        errors++;
      end
      if (got.beep_dur !== want.beep_dur) begin
        $display("%0t: beep_dur mismatch, expected %h, got %h",
                 $time, want.beep_dur, got.beep_dur);
        errors++;
      end
    endfunction
  endclass

  // Clock and DUT-facing signals; every input starts at a known value.
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  beep_scoreboard sb = new();

  int          burst_left = 0;     // items left before the sender idles
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int unsigned cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  timed_note_queue_player u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Receiver: out_stall follows a randomly chosen mode that is held for a random
  // stretch, so there are quiet stretches, light back-pressure and heavy back-pressure.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
      mode_left  <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Result monitor. All inputs change only at the rising edge, so at the
  // falling edge both valid and stall are settled and show what the next
  // rising edge will see: a beep seen here is accepted at that edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_item);
    end
  end

  // Watchdog: a hung handshake or a missing beep ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Duration: mostly short so notes pop often, sometimes anything up to
  // the full 24 bits, sometimes an extreme.
  function automatic logic [DUR_W-1:0] pick_dur();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return DUR_W'($urandom_range(0, 3000));
    if (r < 92) return DUR_W'($urandom_range(0, (1 << DUR_W) - 1));
    if (r < 96) return '0;
    return '1;
  endfunction

  // Elapsed time per tick, shaped the same way as durations.
  function automatic logic [ELAP_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return ELAP_W'($urandom_range(0, 2500));
    if (r < 92) return ELAP_W'($urandom_range(0, (1 << ELAP_W) - 1));
    if (r < 96) return '0;
    return '1;
  endfunction

  // Present one item and hold it until accepted. Called at a rising edge; returns
  // at the accepting edge, or after the idle gap when a burst ends. Valid stays
  // high across a burst and drops only for a gap between bursts.
  task automatic send(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] freq,
                      input logic [DUR_W-1:0] dur, input logic [ELAP_W-1:0] elapsed);
    in_item_t it;
    it.opcode    = op;
    it.note_freq = freq;
    it.note_dur  = dur;
    it.elapsed   = elapsed;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_input(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Hold the sender off until every owed beep is out, then let the block
  // finish any pop it may still have in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int counted;
    int r;

    // Synchronous reset, then release before the first item is sent.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed part ----------------
    // Tick while stopped: ignored, even with the largest elapsed time.
    send(OP_TICK, '1, '1, '1);
    // Unused opcodes: no state change, no beep.
    for (int op = int'(OP_CLEAR) + 1; op < (1 << OP_W); op++) begin
      send(OP_W'(op), '1, '1, '1);
    end
    send(OP_PLAY, '0, '0, '0);
    // Empty queue: countdown goes negative, then is pinned back to zero.
    send(OP_TICK, '0, '0, '1);
    // Smallest and largest notes.
    send(OP_ENQUEUE, '0, '0, '1);
    send(OP_ENQUEUE, '1, '1, '0);
    // Zero elapsed on a zero countdown still pops; a zero-length note
    // leaves the countdown at zero, so the next tick pops again.
    send(OP_TICK, '1, '1, '0);
    send(OP_TICK, '0, '0, '0);
    // Countdown now at its maximum: the largest tick does not expire it.
    send(OP_TICK, '0, '0, '1);
    send(OP_STOP, '0, '0, '0);
    // Clear keeps the store but empties the queue.
    send(OP_CLEAR, '1, '1, '1);
    // Fill: one slot stays empty, so the last enqueue is dropped.
    repeat (QUEUE_SLOTS) begin
      send(OP_ENQUEUE, FREQ_W'($urandom()), DUR_W'($urandom_range(1, 500)),
           ELAP_W'($urandom()));
    end
    send(OP_PLAY, '0, '0, '0);
    send(OP_TICK, '0, '0, '0);
    send(OP_CLEAR, '0, '0, '0);

    // Sender pauses until the block has nothing left to deliver.
    wait_drained();

    // ---------------- random part ----------------
    // Weighted toward enqueue/tick with the player mostly running, so notes
    // keep flowing through the queue; stop, clear, unused opcodes and
    // stopped ticks are the noise. Every item sent counts.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // enqueue burst around the queue size, often long enough to hit the full queue
        repeat ($urandom_range(QUEUE_SLOTS - 2, QUEUE_SLOTS + 2)) begin
          send(OP_ENQUEUE, FREQ_W'($urandom()), pick_dur(), ELAP_W'($urandom()));
          counted++;
        end
      end else if (r < 35) begin
        send(OP_ENQUEUE, FREQ_W'($urandom()), pick_dur(), ELAP_W'($urandom()));
        counted++;
      end else if (r < 75) begin
        send(OP_TICK, FREQ_W'($urandom()), DUR_W'($urandom()), pick_elapsed());
        counted++;
      end else if (r < 85) begin
        send(OP_PLAY, FREQ_W'($urandom()), DUR_W'($urandom()), ELAP_W'($urandom()));
        counted++;
      end else if (r < 89) begin
        send(OP_STOP, FREQ_W'($urandom()), DUR_W'($urandom()), ELAP_W'($urandom()));
        counted++;
      end else if (r < 92) begin
        send(OP_CLEAR, FREQ_W'($urandom()), DUR_W'($urandom()), ELAP_W'($urandom()));
        counted++;
      end else if (r < 97) begin
        send(OP_W'($urandom_range(int'(OP_CLEAR) + 1, (1 << OP_W) - 1)),
             FREQ_W'($urandom()), DUR_W'($urandom()), ELAP_W'($urandom()));
        counted++;
      end else begin
        wait_drained();
      end
    end

    // Drain: every owed beep out, then a settle wait for strays.
    wait_drained();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
